FILE: src/ddmw_pkg.sv
// Shared types, constants and helper functions for the differential drive mixer.
package ddmw_pkg;

    // Speed format: signed fixed point, one is 1 << SPEED_FRAC_BITS.
    localparam int SPEED_FRAC_BITS = 14;
    localparam int SPEED_W         = 16;
    localparam int DUTY_W          = 15;
    localparam int TICK_W          = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic signed [SPEED_W-1:0] SPEED_ONE =
        SPEED_W'(1 << SPEED_FRAC_BITS);

    // Item kinds carried on the action field.
    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 2'd3;

    // Configuration reset values.
    localparam logic [TICK_W-1:0] RST_TIMEOUT   = 16'd8;
    localparam logic [DUTY_W-1:0] RST_MIN_DUTY  = 15'd2458;
    localparam logic [DUTY_W-1:0] RST_TOLERANCE = 15'd16;
    localparam logic [DUTY_W-1:0] RST_DEADBAND  = 15'd164;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic [TICK_W-1:0] timeout_ticks;
        logic [DUTY_W-1:0] min_duty;
        logic [DUTY_W-1:0] change_tolerance;
        logic [DUTY_W-1:0] stop_deadband;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic              left_reverse;
        logic [DUTY_W-1:0] right_duty;
        logic              right_reverse;
        logic              drive_written;
        logic              watchdog_stop;
    } t_result;

    // Clamp a mixed sum to the range minus one to plus one.
    function automatic logic signed [SPEED_W-1:0] clamp_one(
        input logic signed [SPEED_W:0] v
    );
        logic signed [SPEED_W:0] one_w;
        one_w = {SPEED_ONE[SPEED_W-1], SPEED_ONE};
        if (v > one_w) begin
            clamp_one = SPEED_ONE;
        end else if (v < -one_w) begin
            clamp_one = -SPEED_ONE;
        end else begin
            clamp_one = v[SPEED_W-1:0];
        end
    endfunction

    // Magnitude of a clamped speed; it never exceeds one, so it fits a duty.
    function automatic logic [DUTY_W-1:0] speed_mag(
        input logic signed [SPEED_W-1:0] v
    );
        logic [SPEED_W-1:0] a;
        a = v[SPEED_W-1] ? SPEED_W'(-v) : SPEED_W'(v);
        speed_mag = a[DUTY_W-1:0];
    endfunction

    // Magnitude of a difference of two clamped speeds.
    function automatic logic [SPEED_W:0] diff_mag(
        input logic signed [SPEED_W:0] v
    );
        diff_mag = v[SPEED_W] ? (SPEED_W+1)'(-v) : (SPEED_W+1)'(v);
    endfunction

endpackage

FILE: src/ddmw_mix.sv
// Mixing, deadband, change filter and watchdog decision for one transaction.
module ddmw_mix import ddmw_pkg::*; (
    input  logic                      i_action,
    input  logic signed [SPEED_W-1:0] i_linear_speed,
    input  logic signed [SPEED_W-1:0] i_turn_rate,
    input  logic signed [SPEED_W-1:0] i_held_left,
    input  logic signed [SPEED_W-1:0] i_held_right,
    input  logic [TICK_W-1:0]         i_idle_ticks,
    input  t_cfg                      i_cfg,
    output t_result                   o_result,
    output logic signed [SPEED_W-1:0] o_held_left,
    output logic signed [SPEED_W-1:0] o_held_right,
    output logic [TICK_W-1:0]         o_idle_ticks
);

    logic signed [SPEED_W:0]   sum_left;
    logic signed [SPEED_W:0]   sum_right;
    logic signed [SPEED_W-1:0] tgt_left;
    logic signed [SPEED_W-1:0] tgt_right;
    logic [SPEED_W:0]          dlt_left;
    logic [SPEED_W:0]          dlt_right;
    logic [DUTY_W-1:0]         mag_left;
    logic [DUTY_W-1:0]         mag_right;
    logic [TICK_W-1:0]         ticks_inc;
    logic                      unchanged;
    logic                      in_deadband;
    logic                      moving;

    // Arcade mix and clamp of both sides.
    assign sum_left  = {i_linear_speed[SPEED_W-1], i_linear_speed}
                     + {i_turn_rate[SPEED_W-1], i_turn_rate};
    assign sum_right = {i_linear_speed[SPEED_W-1], i_linear_speed}
                     - {i_turn_rate[SPEED_W-1], i_turn_rate};
    assign tgt_left  = clamp_one(sum_left);
    assign tgt_right = clamp_one(sum_right);

    // Distance from the held drive and from standstill.
    assign dlt_left  = diff_mag({tgt_left[SPEED_W-1], tgt_left}
                              - {i_held_left[SPEED_W-1], i_held_left});
    assign dlt_right = diff_mag({tgt_right[SPEED_W-1], tgt_right}
                              - {i_held_right[SPEED_W-1], i_held_right});
    assign mag_left  = speed_mag(tgt_left);
    assign mag_right = speed_mag(tgt_right);

    assign unchanged   = (dlt_left < {2'b00, i_cfg.change_tolerance})
                      && (dlt_right < {2'b00, i_cfg.change_tolerance});
    assign in_deadband = (mag_left < i_cfg.stop_deadband)
                      && (mag_right < i_cfg.stop_deadband);

    // Saturating idle count used by the watchdog.
    assign ticks_inc = (i_idle_ticks == TICK_MAX) ? i_idle_ticks : i_idle_ticks + TICK_W'(1);
    assign moving    = (i_held_left != '0) || (i_held_right != '0);

    // Decision and next held state.
    always_comb begin
        o_result     = '0;
        o_held_left  = i_held_left;
        o_held_right = i_held_right;
        o_idle_ticks = i_idle_ticks;
        case (i_action)
            ACT_TICK: begin
                o_idle_ticks = ticks_inc;
                if ((ticks_inc > i_cfg.timeout_ticks) && moving) begin
                    o_held_left            = '0;
                    o_held_right           = '0;
                    o_result.drive_written = 1'b1;
                    o_result.watchdog_stop = 1'b1;
                end
            end
            ACT_COMMAND: begin
                o_idle_ticks = '0;
                if (!unchanged) begin
                    o_result.drive_written = 1'b1;
                    if (in_deadband) begin
                        o_held_left  = '0;
                        o_held_right = '0;
                    end else begin
                        o_held_left            = tgt_left;
                        o_held_right           = tgt_right;
                        o_result.left_reverse  = tgt_left[SPEED_W-1];
                        o_result.right_reverse = tgt_right[SPEED_W-1];
                        o_result.left_duty     =
                            ((mag_left != '0) && (mag_left < i_cfg.min_duty))
                            ? i_cfg.min_duty : mag_left;
                        o_result.right_duty    =
                            ((mag_right != '0) && (mag_right < i_cfg.min_duty))
                            ? i_cfg.min_duty : mag_right;
                    end
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

FILE: src/differential_drive_mixer_watchdog_core.sv
// Top level of the differential drive mixer with command watchdog.
// Each transaction is a velocity command (linear speed and turn rate, signed
// Q2.14) or one watchdog tick, and gives exactly one result. The block takes
// one transaction per clock while the result side is not stalled: a
// transaction is captured in an input register, then decided against the held
// drive state and written to the result register once the result slot is
// free, and it is presented there until taken. The held drive and idle count
// are updated in the same cycle the decision is made, which lets the next
// transaction follow directly.
// Configuration writes (timeout, minimum duty, change tolerance, stop
// deadband) are always accepted and should only be made while no transaction
// is in flight; no clearing pass is needed after reset.
module differential_drive_mixer_watchdog_core import ddmw_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Item input channel.
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_action,
    input  logic signed [SPEED_W-1:0] i_linear_speed,
    input  logic signed [SPEED_W-1:0] i_turn_rate,
    // Result channel.
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [DUTY_W-1:0]         o_left_duty,
    output logic                      o_left_reverse,
    output logic [DUTY_W-1:0]         o_right_duty,
    output logic                      o_right_reverse,
    output logic                      o_drive_written,
    output logic                      o_watchdog_stop,
    // Configuration write channel.
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    logic                      r_in_valid;
    logic                      r_in_action;
    logic signed [SPEED_W-1:0] r_in_linear;
    logic signed [SPEED_W-1:0] r_in_turn;
    logic                      r_out_valid;
    t_result                   r_result;
    t_cfg                      r_cfg;
    logic signed [SPEED_W-1:0] r_held_left;
    logic signed [SPEED_W-1:0] r_held_right;
    logic [TICK_W-1:0]         r_idle_ticks;

    t_result                   n_result;
    logic signed [SPEED_W-1:0] n_held_left;
    logic signed [SPEED_W-1:0] n_held_right;
    logic [TICK_W-1:0]         n_idle_ticks;

    logic out_free;
    logic advance;
    logic in_take;

    // Handshake: the input register moves on whenever the result slot frees.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (in_take) begin
            r_in_action <= i_action;
            r_in_linear <= i_linear_speed;
            r_in_turn   <= i_turn_rate;
        end
    end

    // Decision logic.
    ddmw_mix u_mix (
        .i_action       (r_in_action),
        .i_linear_speed (r_in_linear),
        .i_turn_rate    (r_in_turn),
        .i_held_left    (r_held_left),
        .i_held_right   (r_held_right),
        .i_idle_ticks   (r_idle_ticks),
        .i_cfg          (r_cfg),
        .o_result       (n_result),
        .o_held_left    (n_held_left),
        .o_held_right   (n_held_right),
        .o_idle_ticks   (n_idle_ticks)
    );

    // Result register and drive state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_held_left  <= '0;
            r_held_right <= '0;
            r_idle_ticks <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_held_left  <= n_held_left;
                r_held_right <= n_held_right;
                r_idle_ticks <= n_idle_ticks;
            end
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks    <= RST_TIMEOUT;
            r_cfg.min_duty         <= RST_MIN_DUTY;
            r_cfg.change_tolerance <= RST_TOLERANCE;
            r_cfg.stop_deadband    <= RST_DEADBAND;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIMEOUT:   r_cfg.timeout_ticks    <= i_cfg_data;
                CFG_MIN_DUTY:  r_cfg.min_duty         <= i_cfg_data[DUTY_W-1:0];
                CFG_TOLERANCE: r_cfg.change_tolerance <= i_cfg_data[DUTY_W-1:0];
                CFG_DEADBAND:  r_cfg.stop_deadband    <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Result ports.
    assign o_out_valid     = r_out_valid;
    assign o_left_duty     = r_result.left_duty;
    assign o_left_reverse  = r_result.left_reverse;
    assign o_right_duty    = r_result.right_duty;
    assign o_right_reverse = r_result.right_reverse;
    assign o_drive_written = r_result.drive_written;
    assign o_watchdog_stop = r_result.watchdog_stop;

    // A result that rewrote nothing carries no drive.
    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_drive_written |->
            o_left_duty == '0 && o_right_duty == '0
            && !o_left_reverse && !o_right_reverse)
        else $error("result without drive write carries drive values");

    // A watchdog stop is a drive write with zero drive.
    a_stop_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_watchdog_stop |->
            o_drive_written && o_left_duty == '0 && o_right_duty == '0)
        else $error("watchdog stop reported without a zero drive write");

    // A processed command clears the idle count.
    a_cmd_clears_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_action == ACT_COMMAND |=> r_idle_ticks == '0)
        else $error("idle count not cleared by a command");

    // Held drive never leaves the clamp range.
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_left <= SPEED_ONE && r_held_left >= -SPEED_ONE
        && r_held_right <= SPEED_ONE && r_held_right >= -SPEED_ONE)
        else $error("held drive outside the clamp range");

endmodule

FILE: verif/tb_differential_drive_mixer_watchdog_core.sv
// Testbench for the differential drive mixer: scoreboard-checked directed and random traffic.
module tb_differential_drive_mixer_watchdog_core;
    import ddmw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASES       = 6;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 4;

    // Tracks the drive state the block should hold and the results it owes.
    class drive_scoreboard;
        t_cfg              cfg;
        int                left_hold;
        int                right_hold;
        logic [TICK_W-1:0] idle_count;
        t_result           expected_q[$];
        int                failures;

        function new();
            cfg.timeout_ticks    = RST_TIMEOUT;
            cfg.min_duty         = RST_MIN_DUTY;
            cfg.change_tolerance = RST_TOLERANCE;
            cfg.stop_deadband    = RST_DEADBAND;
            left_hold  = 0;
            right_hold = 0;
            idle_count = '0;
            failures   = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_TIMEOUT:   cfg.timeout_ticks    = data;
                CFG_MIN_DUTY:  cfg.min_duty         = data[DUTY_W-1:0];
                CFG_TOLERANCE: cfg.change_tolerance = data[DUTY_W-1:0];
                CFG_DEADBAND:  cfg.stop_deadband    = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function int abs_val(input int v);
            return (v < 0) ? -v : v;
        endfunction

        function int clamp_unit(input int v);
            int one;
            one = 1 << SPEED_FRAC_BITS;
            if (v > one) return one;
            if (v < -one) return -one;
            return v;
        endfunction

        // Duty is the magnitude, lifted to the minimum when it is not zero.
        function logic [DUTY_W-1:0] side_duty(input int v);
            int d;
            d = abs_val(v);
            if (d > 0 && d < int'(cfg.min_duty)) d = int'(cfg.min_duty);
            return DUTY_W'(d);
        endfunction

        // Works out the result of one transaction and advances the drive state.
        function t_result mix_drive(input logic action,
                                    input logic signed [SPEED_W-1:0] lin,
                                    input logic signed [SPEED_W-1:0] turn);
            t_result r;
            int      lt;
            int      rt;
            r = '0;
            if (action == ACT_TICK) begin
                if (idle_count != TICK_MAX) idle_count = idle_count + 1'b1;
                if (idle_count > cfg.timeout_ticks && (left_hold != 0 || right_hold != 0)) begin
                    left_hold       = 0;
                    right_hold      = 0;
                    r.drive_written = 1'b1;
                    r.watchdog_stop = 1'b1;
                end
                return r;
            end
            lt = clamp_unit(int'(lin) + int'(turn));
            rt = clamp_unit(int'(lin) - int'(turn));
            idle_count = '0;
            // A command close enough to the held drive changes nothing.
            if (abs_val(lt - left_hold) < int'(cfg.change_tolerance) &&
                abs_val(rt - right_hold) < int'(cfg.change_tolerance)) begin
                return r;
            end
            r.drive_written = 1'b1;
            // Both sides inside the deadband mean stop.
            if (abs_val(lt) < int'(cfg.stop_deadband) &&
                abs_val(rt) < int'(cfg.stop_deadband)) begin
                left_hold  = 0;
                right_hold = 0;
                return r;
            end
            r.left_duty     = side_duty(lt);
            r.left_reverse  = (lt < 0);
            r.right_duty    = side_duty(rt);
            r.right_reverse = (rt < 0);
            left_hold  = lt;
            right_hold = rt;
            return r;
        endfunction

        function void note_input(input logic action,
                                 input logic signed [SPEED_W-1:0] lin,
                                 input logic signed [SPEED_W-1:0] turn);
            expected_q.push_back(mix_drive(action, lin, turn));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function string show(input t_result r);
            return $sformatf("L=%0d rev=%0b R=%0d rev=%0b written=%0b wd_stop=%0b",
                             r.left_duty, r.left_reverse, r.right_duty,
                             r.right_reverse, r.drive_written, r.watchdog_stop);
        endfunction

        function void flag(input string what, input t_result want, input t_result got);
            failures++;
            if (failures <= 10) begin
                $display("mismatch %0d at %0t: %s; expected %s; actual %s",
                         failures, $realtime, what, show(want), show(got));
            end
        endfunction

        // Compares a result with the oldest expectation, field by field.
        function void check_result(input t_result got);
            t_result want;
            string   bad;
            if (expected_q.size() == 0) begin
                flag("result with no transaction pending", '0, got);
                return;
            end
            want = expected_q.pop_front();
            bad  = "";
            if (got.left_duty !== want.left_duty) bad = {bad, " left_duty"};
            if (got.left_reverse !== want.left_reverse) bad = {bad, " left_reverse"};
            if (got.right_duty !== want.right_duty) bad = {bad, " right_duty"};
            if (got.right_reverse !== want.right_reverse) bad = {bad, " right_reverse"};
            if (got.drive_written !== want.drive_written) bad = {bad, " drive_written"};
            if (got.watchdog_stop !== want.watchdog_stop) bad = {bad, " watchdog_stop"};
            if (bad != "") flag({"wrong field(s):", bad}, want, got);
        endfunction
    endclass

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_in_valid      = 1'b0;
    logic                      o_in_ready;
    logic                      i_action        = 1'b0;
    logic signed [SPEED_W-1:0] i_linear_speed  = '0;
    logic signed [SPEED_W-1:0] i_turn_rate     = '0;
    logic                      o_out_valid;
    logic                      i_out_ready     = 1'b0;
    logic [DUTY_W-1:0]         o_left_duty;
    logic                      o_left_reverse;
    logic [DUTY_W-1:0]         o_right_duty;
    logic                      o_right_reverse;
    logic                      o_drive_written;
    logic                      o_watchdog_stop;
    logic                      i_cfg_valid     = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data      = '0;

    drive_scoreboard           sb;
    int                        cycle_count;
    int                        burst_left;
    int                        stall_left;
    int                        stall_mode;
    int                        mode_left;
    logic signed [SPEED_W-1:0] last_lin;
    logic signed [SPEED_W-1:0] last_turn;

    differential_drive_mixer_watchdog_core i_dut (.*);

    // Free-running clock.
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Run limit: a hang ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side stalls in modes: none, light and heavy.
    initial begin
        stall_left = 0;
        stall_mode = 0;
        mode_left  = 0;
    end

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left = mode_left - 1;
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            case (stall_mode)
                1: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 8);
                default: ;
            endcase
        end
    end

    // Every accepted result goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result({o_left_duty, o_left_reverse, o_right_duty,
                             o_right_reverse, o_drive_written, o_watchdog_stop});
        end
    end

    // Sender bursts: a gap opens each burst, then items follow back to back.
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
        return $urandom_range(1, 6);
    endfunction

    task automatic send_item(input logic action,
                             input logic signed [SPEED_W-1:0] lin,
                             input logic signed [SPEED_W-1:0] turn);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_action       <= action;
        i_linear_speed <= lin;
        i_turn_rate    <= turn;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(action, lin, turn);
    endtask

    task automatic send_cmd(input logic signed [SPEED_W-1:0] lin,
                            input logic signed [SPEED_W-1:0] turn);
        send_item(ACT_COMMAND, lin, turn);
        last_lin  = lin;
        last_turn = turn;
    endtask

    // Speed fields carry random bits on a tick; the block must ignore them.
    task automatic send_tick();
        send_item(ACT_TICK, SPEED_W'($urandom), SPEED_W'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(index, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] timeout,
                             input logic [CFG_DATA_W-1:0] min_duty,
                             input logic [CFG_DATA_W-1:0] tolerance,
                             input logic [CFG_DATA_W-1:0] deadband);
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_MIN_DUTY, min_duty);
        write_reg(CFG_TOLERANCE, tolerance);
        write_reg(CFG_DEADBAND, deadband);
    endtask

    // Holds off the sender until every owed result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SPEED_W-1:0] corner_speed();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return -16'sd16384;
            3: return 16'sd16384;
            4: return -16'sd1;
            5: return 16'sd1;
            6: return 16'sd8192;
            default: return 16'sd0;
        endcase
    endfunction

    // Picks a setting for each register, extremes included.
    task automatic random_config();
        logic [CFG_DATA_W-1:0] timeout;
        logic [CFG_DATA_W-1:0] min_duty;
        logic [CFG_DATA_W-1:0] tolerance;
        logic [CFG_DATA_W-1:0] deadband;
        case ($urandom_range(0, 5))
            0: timeout = 16'd0;
            1: timeout = 16'hFFFF;
            2: timeout = 16'($urandom);
            default: timeout = 16'($urandom_range(1, 10));
        endcase
        case ($urandom_range(0, 5))
            0: min_duty = 16'd0;
            1: min_duty = 16'd16384;
            2: min_duty = 16'($urandom);
            3: min_duty = 16'd32767;
            default: min_duty = 16'($urandom_range(0, 4000));
        endcase
        case ($urandom_range(0, 5))
            0: tolerance = 16'd0;
            1: tolerance = 16'd16384;
            2: tolerance = 16'($urandom);
            default: tolerance = 16'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 5))
            0: deadband = 16'd0;
            1: deadband = 16'd16384;
            2: deadband = 16'($urandom);
            default: deadband = 16'($urandom_range(0, 600));
        endcase
        configure(timeout, min_duty, tolerance, deadband);
    endtask

    // Random traffic: commands of several shapes and runs of ticks that can reach a small timeout.
    task automatic random_phase(input int count);
        int                        n;
        int                        kind;
        int                        run_len;
        logic signed [SPEED_W-1:0] lin;
        logic signed [SPEED_W-1:0] turn;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                if (sb.cfg.timeout_ticks < 16) begin
                    run_len = $urandom_range(1, int'(sb.cfg.timeout_ticks) + 3);
                end else begin
                    run_len = $urandom_range(1, 12);
                end
                repeat (run_len) send_tick();
                n += run_len;
            end else begin
                if (kind < 50) begin
                    lin  = SPEED_W'($urandom);
                    turn = SPEED_W'($urandom);
                end else if (kind < 65) begin
                    // Small step from the last command, around the change tolerance.
                    lin  = SPEED_W'(int'(last_lin) + int'($urandom_range(0, 40)) - 20);
                    turn = SPEED_W'(int'(last_turn) + int'($urandom_range(0, 40)) - 20);
                end else if (kind < 80) begin
                    lin  = SPEED_W'(int'($urandom_range(0, 800)) - 400);
                    turn = SPEED_W'(int'($urandom_range(0, 800)) - 400);
                end else if (kind < 90) begin
                    lin  = SPEED_W'(int'($urandom_range(0, 32768)) - 16384);
                    turn = SPEED_W'(int'($urandom_range(0, 32768)) - 16384);
                end else begin
                    lin  = corner_speed();
                    turn = corner_speed();
                end
                send_cmd(lin, turn);
                n++;
            end
            if ($urandom_range(0, 199) == 0) drain_results();
        end
    endtask

    // Main sequence.
    initial begin
        sb         = new();
        burst_left = 0;
        last_lin   = '0;
        last_turn  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero command, full-scale mixes and clamping.
        send_cmd(16'sd0, 16'sd0);
        send_cmd(16'sh7FFF, 16'sh7FFF);
        send_cmd(16'sh8000, 16'sh8000);
        send_cmd(16'sh8000, 16'sh7FFF);
        send_cmd(16'sh7FFF, 16'sh8000);
        send_cmd(16'sh7FFF, 16'sh8000);
        // Change tolerance: a step of exactly the tolerance counts as a change.
        send_cmd(16'sd8192, 16'sd8192);
        send_cmd(16'sd8184, 16'sd8184);
        send_cmd(16'sd8177, 16'sd8177);
        // Deadband stop, then a drive that the watchdog cuts off.
        send_cmd(16'sd100, -16'sd50);
        send_cmd(16'sd5000, 16'sd0);
        repeat (9) send_tick();
        send_tick();
        send_cmd(16'sd0, 16'sd200);
        drain_results();

        // Zero timeout, minimum duty above one, no tolerance and no deadband.
        configure(16'd0, 16'd32767, 16'd0, 16'd0);
        send_tick();
        send_cmd(16'sd1, 16'sd0);
        send_cmd(16'sd1, 16'sd0);
        send_tick();
        send_cmd(16'sd0, 16'sd0);
        send_cmd(-16'sd3000, 16'sd1000);
        drain_results();

        // Largest timeout never fires over a long run of ticks.
        configure(16'hFFFF, 16'(RST_MIN_DUTY), 16'(RST_TOLERANCE), 16'(RST_DEADBAND));
        send_cmd(16'sd4000, -16'sd1000);
        repeat (40) send_tick();
        drain_results();
        // With the count already past a lower timeout, the next tick fires.
        write_reg(CFG_TIMEOUT, 16'd30);
        send_tick();
        drain_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            random_config();
            random_phase(RANDOM_ITEMS / PHASES);
            drain_results();
        end

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
src/ddmw_pkg.sv
src/ddmw_mix.sv
src/differential_drive_mixer_watchdog_core.sv
verif/tb_differential_drive_mixer_watchdog_core.sv
